FILE: hdl/rcv_pkg.sv
// ----------------------------------------------------------------------------
// rcv_pkg: shared types and constants for the 3x3 RGB convolution block
// Holds the register index codes, reset values, and the structs that pass
// between the configuration, scan, neighbourhood and accumulate stages.
// ----------------------------------------------------------------------------
package rcv_pkg;

    localparam int PIX_W   = 24;   // packed RGB, red in bits 7:0
    localparam int CHAN_W  = 8;
    localparam int SIZE_W  = 12;   // frame_width / frame_height registers
    localparam int PROD_W  = 16;   // s8 * u8 fits in 16 signed bits
    localparam int ACC_W   = 20;   // sum of nine products

    localparam logic [PIX_W-1:0]  COEF_TOP_RST = 24'hFFFFFF;
    localparam logic [PIX_W-1:0]  COEF_MID_RST = 24'hFF08FF;
    localparam logic [PIX_W-1:0]  COEF_BOT_RST = 24'hFFFFFF;
    localparam logic [SIZE_W-1:0] WIDTH_RST    = 12'd640;
    localparam logic [SIZE_W-1:0] HEIGHT_RST   = 12'd480;
    localparam logic [SIZE_W-1:0] SIZE_MIN     = 12'd3;

    localparam logic [CHAN_W-1:0] CHAN_MAX     = 8'd255;

    typedef enum logic [2:0] {
        REG_COEF_TOP = 3'd0,
        REG_COEF_MID = 3'd1,
        REG_COEF_BOT = 3'd2,
        REG_WIDTH    = 3'd3,
        REG_HEIGHT   = 3'd4
    } cfg_reg_t;

    // kernel rows, left coefficient in the low byte of each row
    typedef struct packed {
        logic [PIX_W-1:0] bot;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] top;
    } coef_t;

    // per-pixel flags decided at input time
    typedef struct packed {
        logic produce;
        logic frame_last;
    } tag_t;

    typedef logic [PROD_W-1:0] prod_t;
    typedef prod_t [2:0][8:0]  prod_set_t;   // [channel][3*row + column]

endpackage

FILE: hdl/rcv_ram.sv
// ----------------------------------------------------------------------------
// rcv_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rcv_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/rcv_cfg.sv
// ----------------------------------------------------------------------------
// rcv_cfg: configuration register file
// Holds the kernel rows and frame size; presents the size clamped to the
// range the line stores support.
// ----------------------------------------------------------------------------
module rcv_cfg #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [2:0]                      cfg_index,
    input  logic [rcv_pkg::PIX_W-1:0]       cfg_wdata,
    output rcv_pkg::coef_t                  coef,
    output logic [$clog2(MAX_WIDTH):0]      width_eff,
    output logic [$clog2(MAX_HEIGHT):0]     height_eff
);

    localparam int WSW  = $clog2(MAX_WIDTH) + 1;
    localparam int HSW  = $clog2(MAX_HEIGHT) + 1;
    localparam int WCMP = (WSW > rcv_pkg::SIZE_W) ? WSW : rcv_pkg::SIZE_W;
    localparam int HCMP = (HSW > rcv_pkg::SIZE_W) ? HSW : rcv_pkg::SIZE_W;

    rcv_pkg::coef_t                coef_reg;
    logic [rcv_pkg::SIZE_W-1:0]    width_reg;
    logic [rcv_pkg::SIZE_W-1:0]    height_reg;
    logic [WCMP-1:0]               width_wide;
    logic [HCMP-1:0]               height_wide;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg.top <= rcv_pkg::COEF_TOP_RST;
            coef_reg.mid <= rcv_pkg::COEF_MID_RST;
            coef_reg.bot <= rcv_pkg::COEF_BOT_RST;
            width_reg    <= rcv_pkg::WIDTH_RST;
            height_reg   <= rcv_pkg::HEIGHT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                rcv_pkg::REG_COEF_TOP: coef_reg.top <= cfg_wdata;
                rcv_pkg::REG_COEF_MID: coef_reg.mid <= cfg_wdata;
                rcv_pkg::REG_COEF_BOT: coef_reg.bot <= cfg_wdata;
                rcv_pkg::REG_WIDTH:    width_reg    <= cfg_wdata[rcv_pkg::SIZE_W-1:0];
                rcv_pkg::REG_HEIGHT:   height_reg   <= cfg_wdata[rcv_pkg::SIZE_W-1:0];
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    // clamp size to 3..MAX
    always_comb begin
        width_wide  = WCMP'(width_reg);
        height_wide = HCMP'(height_reg);
        if (width_reg < rcv_pkg::SIZE_MIN) begin
            width_wide = WCMP'(rcv_pkg::SIZE_MIN);
        end else if (width_wide > WCMP'(MAX_WIDTH)) begin
            width_wide = WCMP'(MAX_WIDTH);
        end
        if (height_reg < rcv_pkg::SIZE_MIN) begin
            height_wide = HCMP'(rcv_pkg::SIZE_MIN);
        end else if (height_wide > HCMP'(MAX_HEIGHT)) begin
            height_wide = HCMP'(MAX_HEIGHT);
        end
    end

    assign coef       = coef_reg;
    assign width_eff  = width_wide[WSW-1:0];
    assign height_eff = height_wide[HSW-1:0];

endmodule

FILE: hdl/rcv_scan.sv
// ----------------------------------------------------------------------------
// rcv_scan: raster position counters
// Tracks column and row of the next pixel and flags whether it completes a
// window and whether it closes the frame.
// ----------------------------------------------------------------------------
module rcv_scan #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            advance,
    input  logic [$clog2(MAX_WIDTH):0]      width_eff,
    input  logic [$clog2(MAX_HEIGHT):0]     height_eff,
    output logic [$clog2(MAX_WIDTH)-1:0]    col,
    output rcv_pkg::tag_t                   tag
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic          row_end;
    logic          frame_last;

    assign row_end    = ({1'b0, col_reg} + (CW+1)'(1)) >= width_eff;
    assign frame_last = row_end && (({1'b0, row_reg} + (RW+1)'(1)) >= height_eff);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (advance) begin
            if (row_end) begin
                col_reg <= '0;
                row_reg <= frame_last ? '0 : row_reg + RW'(1);
            end else begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    assign col            = col_reg;
    assign tag.produce    = (col_reg >= CW'(2)) && (row_reg >= RW'(2));
    assign tag.frame_last = frame_last;

endmodule

FILE: hdl/rcv_nbhd.sv
// ----------------------------------------------------------------------------
// rcv_nbhd: line stores, 3x3 window and kernel products
// Reads the two rows above on transfer, then builds the neighbourhood,
// writes the rows back shifted down and registers all 27 products.
// ----------------------------------------------------------------------------
module rcv_nbhd #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_accept,
    input  logic [rcv_pkg::PIX_W-1:0]       in_pix,
    input  logic [$clog2(MAX_WIDTH)-1:0]    in_col,
    input  rcv_pkg::tag_t                   in_tag,
    input  rcv_pkg::coef_t                  coef,
    output logic                            in_ready,
    input  logic                            prod_take,
    output logic                            prod_valid,
    output rcv_pkg::prod_set_t              prod_set,
    output logic                            prod_last
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic                        s1_valid_reg;
    logic [rcv_pkg::PIX_W-1:0]   s1_pix_reg;
    logic [CW-1:0]               s1_col_reg;
    rcv_pkg::tag_t               s1_tag_reg;
    logic                        s1_go;

    logic [rcv_pkg::PIX_W-1:0]   win_reg [6];
    logic [rcv_pkg::PIX_W-1:0]   up1;
    logic [rcv_pkg::PIX_W-1:0]   up2;
    logic [rcv_pkg::PIX_W-1:0]   nb [3][3];
    logic [rcv_pkg::PIX_W-1:0]   rows [3];

    logic                        s2_valid_reg;
    rcv_pkg::prod_set_t          s2_prod_reg;
    rcv_pkg::prod_set_t          s2_prod_next;
    logic                        s2_last_reg;
    logic                        s2_free;

    // row r-1 store
    rcv_ram #(.WIDTH(rcv_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_line_a (
        .aclk    (aclk),
        .wr_en   (s1_go),
        .wr_addr (s1_col_reg),
        .wr_data (s1_pix_reg),
        .rd_en   (in_accept),
        .rd_addr (in_col),
        .rd_data (up1)
    );

    // row r-2 store
    rcv_ram #(.WIDTH(rcv_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_line_b (
        .aclk    (aclk),
        .wr_en   (s1_go),
        .wr_addr (s1_col_reg),
        .wr_data (up1),
        .rd_en   (in_accept),
        .rd_addr (in_col),
        .rd_data (up2)
    );

    assign s2_free  = !s2_valid_reg || prod_take;
    assign s1_go    = s1_valid_reg && (!s1_tag_reg.produce || s2_free);
    assign in_ready = !s1_valid_reg || s1_go;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nb[i][0] = win_reg[i];
            nb[i][1] = win_reg[3+i];
        end
        nb[0][2] = up2;
        nb[1][2] = up1;
        nb[2][2] = s1_pix_reg;
        rows[0]  = coef.top;
        rows[1]  = coef.mid;
        rows[2]  = coef.bot;
    end

    always_comb begin
        logic signed [rcv_pkg::PROD_W:0] p;
        p = '0;
        for (int ch = 0; ch < 3; ch++) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    p = $signed(rows[i][8*k +: 8])
                      * $signed({1'b0, nb[i][k][8*ch +: 8]});
                    s2_prod_next[ch][3*i+k] = p[rcv_pkg::PROD_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            if (in_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_go) begin
                s1_valid_reg <= 1'b0;
            end

            // shift the window one column left
            if (s1_go) begin
                for (int i = 0; i < 3; i++) begin
                    win_reg[i]   <= nb[i][1];
                    win_reg[3+i] <= nb[i][2];
                end
            end

            if (s1_go && s1_tag_reg.produce) begin
                s2_valid_reg <= 1'b1;
            end else if (prod_take) begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_pix_reg <= in_pix;
            s1_col_reg <= in_col;
            s1_tag_reg <= in_tag;
        end
        if (s1_go && s1_tag_reg.produce) begin
            s2_prod_reg <= s2_prod_next;
            s2_last_reg <= s1_tag_reg.frame_last;
        end
    end

    assign prod_valid = s2_valid_reg;
    assign prod_set   = s2_prod_reg;
    assign prod_last  = s2_last_reg;

endmodule

FILE: hdl/rcv_mac.sv
// ----------------------------------------------------------------------------
// rcv_mac: per-channel sum, clamp and result register
// Adds the nine products of each channel, clamps to 0..255 and holds the
// result until the downstream side takes it.
// ----------------------------------------------------------------------------
module rcv_mac (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         prod_valid,
    input  rcv_pkg::prod_set_t           prod_set,
    input  logic                         prod_last,
    output logic                         prod_take,
    output logic                         out_valid,
    output logic [rcv_pkg::PIX_W-1:0]    out_pix,
    output logic                         out_last,
    input  logic                         out_ready
);

    logic                        out_valid_reg;
    logic [rcv_pkg::PIX_W-1:0]   out_pix_reg;
    logic [rcv_pkg::PIX_W-1:0]   out_pix_next;
    logic                        out_last_reg;

    assign prod_take = !out_valid_reg || out_ready;

    always_comb begin
        logic signed [rcv_pkg::ACC_W-1:0] acc;
        logic [rcv_pkg::PROD_W-1:0]       p;
        acc = '0;
        p   = '0;
        out_pix_next = '0;
        for (int ch = 0; ch < 3; ch++) begin
            acc = '0;
            for (int j = 0; j < 9; j++) begin
                p   = prod_set[ch][j];
                acc = acc + $signed({{(rcv_pkg::ACC_W-rcv_pkg::PROD_W){p[rcv_pkg::PROD_W-1]}},
                                     p});
            end
            if (acc[rcv_pkg::ACC_W-1]) begin
                out_pix_next[8*ch +: 8] = '0;
            end else if (acc > $signed(rcv_pkg::ACC_W'(rcv_pkg::CHAN_MAX))) begin
                out_pix_next[8*ch +: 8] = rcv_pkg::CHAN_MAX;
            end else begin
                out_pix_next[8*ch +: 8] = acc[7:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (prod_take) begin
            out_valid_reg <= prod_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_take && prod_valid) begin
            out_pix_reg  <= out_pix_next;
            out_last_reg <= prod_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pix   = out_pix_reg;
    assign out_last  = out_last_reg;

endmodule

FILE: hdl/rgb_conv3x3_valid_clamp.sv
// ----------------------------------------------------------------------------
// rgb_conv3x3_valid_clamp: streaming 3x3 RGB convolution, valid region only
// Line stores keep the two rows above; each channel is convolved with a
// programmable signed kernel and clamped to 0..255.
// ----------------------------------------------------------------------------
//  channel | ports                        | payload
//  --------+------------------------------+-----------------------------------
//  pixels  | s_tvalid s_tready s_tdata    | red, green, blue (low bits first)
//  results | m_tvalid m_tready m_tdata    | out_red, out_green, out_blue
//          | m_tlast                      | frame_end
//  config  | cfg_wr_en cfg_index cfg_wdata| coef rows, frame width, height
//
//  Sustains one pixel transfer per clock while results are taken; a frame of
//  W x H pixels yields (W-2) x (H-2) results, each passing through the input
//  register (line-store read beside it), product register and result register.
//  Reset is synchronous; line stores are not cleared and take no init pass.
//  With m_tready low, s_tready drops once results fill the product and result
//  registers and the next window-completing pixel waits in the input register.
// ----------------------------------------------------------------------------
module rgb_conv3x3_valid_clamp #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [rcv_pkg::PIX_W-1:0]    s_tdata,    // pix_red, pix_green, pix_blue

    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [rcv_pkg::PIX_W-1:0]    m_tdata,    // out_red, out_green, out_blue
    output logic                         m_tlast,    // frame_end

    input  logic                         cfg_wr_en,
    input  logic [2:0]                   cfg_index,
    input  logic [rcv_pkg::PIX_W-1:0]    cfg_wdata
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    rcv_pkg::coef_t       coef;
    logic [CW:0]          width_eff;
    logic [RW:0]          height_eff;
    logic [CW-1:0]        col;
    rcv_pkg::tag_t        tag;
    logic                 in_accept;
    logic                 prod_valid;
    logic                 prod_take;
    logic                 prod_last;
    rcv_pkg::prod_set_t   prod_set;

    assign in_accept = s_tvalid && s_tready;

    rcv_cfg #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .coef       (coef),
        .width_eff  (width_eff),
        .height_eff (height_eff)
    );

    rcv_scan #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (in_accept),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .col        (col),
        .tag        (tag)
    );

    rcv_nbhd #(.MAX_WIDTH(MAX_WIDTH)) u_nbhd (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .in_pix     (s_tdata),
        .in_col     (col),
        .in_tag     (tag),
        .coef       (coef),
        .in_ready   (s_tready),
        .prod_take  (prod_take),
        .prod_valid (prod_valid),
        .prod_set   (prod_set),
        .prod_last  (prod_last)
    );

    rcv_mac u_mac (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .prod_valid (prod_valid),
        .prod_set   (prod_set),
        .prod_last  (prod_last),
        .prod_take  (prod_take),
        .out_valid  (m_tvalid),
        .out_pix    (m_tdata),
        .out_last   (m_tlast),
        .out_ready  (m_tready)
    );

endmodule

FILE: hdl/rcv_chk.sv
// ----------------------------------------------------------------------------
// rcv_chk: port-level checks for the 3x3 convolution block
// Watches the top-level ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module rcv_chk (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tready,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [rcv_pkg::PIX_W-1:0]    m_tdata,
    input  logic                         m_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // reset empties the result register
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // input back-pressure only comes from a blocked result
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back-pressure");

    // the three-stage path cannot deliver a result straight out of reset
    a_min_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !m_tvalid ##1 !m_tvalid ##1 !m_tvalid)
        else $error("result appeared too soon after reset");

endmodule

bind rgb_conv3x3_valid_clamp rcv_chk u_chk (.*);

FILE: sim/tb_rgb_conv3x3_valid_clamp.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb_conv3x3_valid_clamp: self-checking bench for the 3x3 RGB convolution
// Streams whole frames through the block under several kernels and frame
// sizes, and predicts every result in a scoreboard that keeps its own line
// stores and window. Both stream sides idle at random, the result side also
// holds off for a long stretch, and every result is checked field by field.
// ----------------------------------------------------------------------------
module tb_rgb_conv3x3_valid_clamp;

    localparam int MAX_W          = 2048;
    localparam int MAX_H          = 2048;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PIPE_PAD       = 8;
    localparam int RANDOM_ITEMS   = 700;
    localparam int QUIET_TAIL     = 150;

    typedef enum {PX_RANDOM, PX_BINARY, PX_SPOT_HI, PX_SPOT_LO} pix_kind_t;

    // packed like m_tlast & m_tdata, red in the low byte
    typedef struct packed {
        logic                       frame_end;
        logic [rcv_pkg::CHAN_W-1:0] out_blue;
        logic [rcv_pkg::CHAN_W-1:0] out_green;
        logic [rcv_pkg::CHAN_W-1:0] out_red;
    } conv_result_t;

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [rcv_pkg::PIX_W-1:0]  s_tdata;     // pix_red, pix_green, pix_blue
    logic                       m_tvalid;
    logic                       m_tready;
    logic [rcv_pkg::PIX_W-1:0]  m_tdata;     // out_red, out_green, out_blue
    logic                       m_tlast;     // frame_end
    logic                       cfg_wr_en;
    logic [2:0]                 cfg_index;
    logic [rcv_pkg::PIX_W-1:0]  cfg_wdata;

    logic hold_request;
    logic rx_idle_on;
    bit   tx_gaps;

    always #5 aclk = ~aclk;

    rgb_conv3x3_valid_clamp #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    class conv_scoreboard;
        logic [rcv_pkg::PIX_W-1:0]  coef_top, coef_mid, coef_bot;
        logic [rcv_pkg::SIZE_W-1:0] width_reg, height_reg;
        logic [rcv_pkg::PIX_W-1:0]  row_up1 [MAX_W];   // row r-1
        logic [rcv_pkg::PIX_W-1:0]  row_up2 [MAX_W];   // row r-2
        logic [rcv_pkg::PIX_W-1:0]  win [6];    // columns c-2 then c-1, rows r-2..r
        int unsigned                col, row;
        conv_result_t               due_results[$];
        int                         errors;

        function new();
            coef_top   = rcv_pkg::COEF_TOP_RST;
            coef_mid   = rcv_pkg::COEF_MID_RST;
            coef_bot   = rcv_pkg::COEF_BOT_RST;
            width_reg  = rcv_pkg::WIDTH_RST;
            height_reg = rcv_pkg::HEIGHT_RST;
            foreach (row_up1[i]) begin
                row_up1[i] = '0;
                row_up2[i] = '0;
            end
            foreach (win[i]) win[i] = '0;
            col    = 0;
            row    = 0;
            errors = 0;
        endfunction

        function int unsigned clip_size(logic [rcv_pkg::SIZE_W-1:0] v, int unsigned top);
            if (v < rcv_pkg::SIZE_MIN) return rcv_pkg::SIZE_MIN;
            if (v > top) return top;
            return v;
        endfunction

        function void write_reg(logic [2:0] idx, logic [rcv_pkg::PIX_W-1:0] val);
            case (rcv_pkg::cfg_reg_t'(idx))
                rcv_pkg::REG_COEF_TOP: coef_top   = val;
                rcv_pkg::REG_COEF_MID: coef_mid   = val;
                rcv_pkg::REG_COEF_BOT: coef_bot   = val;
                rcv_pkg::REG_WIDTH:    width_reg  = val[rcv_pkg::SIZE_W-1:0];
                rcv_pkg::REG_HEIGHT:   height_reg = val[rcv_pkg::SIZE_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // advance the window by one pixel and queue a result where it is complete
        function void take_pixel(logic [rcv_pkg::PIX_W-1:0] px);
            int unsigned                w, h, i, k, ch;
            logic [rcv_pkg::PIX_W-1:0]  up1, up2;
            logic [rcv_pkg::PIX_W-1:0]  nb [3][3];
            logic [rcv_pkg::PIX_W-1:0]  k_rows [3];
            logic [rcv_pkg::CHAN_W-1:0] chan_out [3];
            bit                         row_end, last_px;
            int                         acc, coef, pix_val;
            conv_result_t               res;

            w       = clip_size(width_reg, MAX_W);
            h       = clip_size(height_reg, MAX_H);
            up1     = row_up1[col];
            up2     = row_up2[col];
            row_end = (col + 1 >= w);
            last_px = row_end && (row + 1 >= h);
            row_up2[col] = up1;
            row_up1[col] = px;
            for (i = 0; i < 3; i++) begin
                nb[i][0] = win[i];
                nb[i][1] = win[3 + i];
            end
            nb[0][2] = up2;
            nb[1][2] = up1;
            nb[2][2] = px;

            if (col >= 2 && row >= 2) begin
                k_rows[0] = coef_top;
                k_rows[1] = coef_mid;
                k_rows[2] = coef_bot;
                for (ch = 0; ch < 3; ch++) begin
                    acc = 0;
                    for (i = 0; i < 3; i++) begin
                        for (k = 0; k < 3; k++) begin
                            coef    = $signed(k_rows[i][8*k +: 8]);
                            pix_val = nb[i][k][8*ch +: 8];
                            acc    += coef * pix_val;
                        end
                    end
                    if (acc < 0) acc = 0;
                    if (acc > rcv_pkg::CHAN_MAX) acc = rcv_pkg::CHAN_MAX;
                    chan_out[ch] = acc[rcv_pkg::CHAN_W-1:0];
                end
                res.out_red   = chan_out[0];
                res.out_green = chan_out[1];
                res.out_blue  = chan_out[2];
                res.frame_end = last_px;
                due_results.push_back(res);
            end

            for (i = 0; i < 3; i++) begin
                win[i]     = nb[i][1];
                win[3 + i] = nb[i][2];
            end
            if (row_end) begin
                col = 0;
                row = (row + 1 >= h) ? 0 : row + 1;
            end else begin
                col++;
            end
        endfunction

        function void report(string field, logic [rcv_pkg::CHAN_W-1:0] want,
                             logic [rcv_pkg::CHAN_W-1:0] got);
            $display("%0t: %s expected %h, got %h", $time, field, want, got);
            errors++;
        endfunction

        function void check_result(logic [rcv_pkg::PIX_W-1:0] data, logic last);
            conv_result_t want, got;
            got = {last, data};
            if (due_results.size() == 0) begin
                $display("%0t: result %h frame_end %b arrived, none expected",
                         $time, data, last);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (got.out_red !== want.out_red)
                report("out_red", want.out_red, got.out_red);
            if (got.out_green !== want.out_green)
                report("out_green", want.out_green, got.out_green);
            if (got.out_blue !== want.out_blue)
                report("out_blue", want.out_blue, got.out_blue);
            if (got.frame_end !== want.frame_end)
                report("frame_end", want.frame_end, got.frame_end);
        endfunction
    endclass

    conv_scoreboard sb;

    // every transfer and register write is seen here, in the order it happens
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) sb.write_reg(cfg_index, cfg_wdata);
            if (s_tvalid && s_tready) sb.take_pixel(s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
        end
    end

    initial begin
        int unsigned stalled_cycles;
        stalled_cycles = 0;
        while (stalled_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                stalled_cycles = 0;
            else
                stalled_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int stall;
        stall = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                stall = HOLD_CYCLES;
                hold_request <= 1'b0;
            end else if (stall == 0 && rx_idle_on && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 7);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic logic [rcv_pkg::PIX_W-1:0] pick_pixel(pix_kind_t kind,
                                                             int unsigned x,
                                                             int unsigned y);
        logic [rcv_pkg::PIX_W-1:0] px;
        int ch;
        case (kind)
            PX_SPOT_HI: px = (x == 1 && y == 1) ? '1 : '0;
            PX_SPOT_LO: px = (x == 1 && y == 1) ? '0 : '1;
            PX_BINARY: begin
                for (ch = 0; ch < 3; ch++)
                    px[8*ch +: 8] = $urandom_range(0, 1) ? rcv_pkg::CHAN_MAX : '0;
            end
            default: px = rcv_pkg::PIX_W'($urandom);
        endcase
        return px;
    endfunction

    // style 0: any bytes, 1: small signed taps, 2: taps of 0 or 1
    function automatic logic [rcv_pkg::PIX_W-1:0] pick_kernel_row(int style);
        logic [rcv_pkg::PIX_W-1:0] r;
        int i;
        r = rcv_pkg::PIX_W'($urandom);
        if (style != 0) begin
            for (i = 0; i < 3; i++)
                r[8*i +: 8] = (style == 1) ? 8'(int'($urandom_range(0, 4)) - 2)
                                           : 8'($urandom_range(0, 1));
        end
        return r;
    endfunction

    task automatic send_pixel(input logic [rcv_pkg::PIX_W-1:0] px);
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_rows(input int unsigned w, input int unsigned rows,
                             input pix_kind_t kind);
        int unsigned x, y;
        for (y = 0; y < rows; y++)
            for (x = 0; x < w; x++)
                send_pixel(pick_pixel(kind, x, y));
    endtask

    // stop offering, wait for every queued result, then let the pipe empty
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (PIPE_PAD) @(posedge aclk);
    endtask

    // leaves cfg_wr_en high; the caller drops it after the last write
    task automatic write_reg(input logic [2:0] idx, input logic [rcv_pkg::PIX_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic configure(input logic [rcv_pkg::PIX_W-1:0] top, mid, bot, w_val, h_val);
        drain_results();
        write_reg(rcv_pkg::REG_COEF_TOP, top);
        write_reg(rcv_pkg::REG_COEF_MID, mid);
        write_reg(rcv_pkg::REG_COEF_BOT, bot);
        write_reg(rcv_pkg::REG_WIDTH, w_val);
        write_reg(rcv_pkg::REG_HEIGHT, h_val);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int unsigned               w, h, nframes, done_items, phase, f;
        logic [rcv_pkg::PIX_W-1:0] w_val, h_val;
        int                        style;
        bit                        quiet;
        pix_kind_t                 kind;

        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= '0;
        cfg_wdata    <= '0;
        hold_request <= 1'b0;
        rx_idle_on   <= 1'b0;
        tx_gaps      = 0;
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // reset kernel: a lone bright pixel saturates high, a lone dark one low
        write_reg(rcv_pkg::REG_WIDTH, 3);
        write_reg(rcv_pkg::REG_HEIGHT, 3);
        cfg_wr_en <= 1'b0;
        send_rows(3, 3, PX_SPOT_HI);
        send_rows(3, 3, PX_SPOT_LO);

        // extreme taps, sizes below the minimum, unused register indexes
        configure(24'h7F807F, 24'h807F80, 24'h7F0180, 24'h000000, 24'hFFF002);
        for (int i = int'(rcv_pkg::REG_HEIGHT) + 1; i < (1 << $bits(cfg_index)); i++)
            write_reg(3'(i), '1);
        cfg_wr_en <= 1'b0;
        send_rows(3, 3, PX_BINARY);

        // mid-frame size changes: shorten the frame, then narrow it at a row end
        tx_gaps = 1;
        rx_idle_on <= 1'b1;
        configure(pick_kernel_row(1), pick_kernel_row(1), pick_kernel_row(1), 6, 10);
        send_rows(6, 4, PX_RANDOM);
        drain_results();
        write_reg(rcv_pkg::REG_HEIGHT, 5);
        cfg_wr_en <= 1'b0;
        send_rows(6, 1, PX_RANDOM);
        configure(pick_kernel_row(2), pick_kernel_row(2), pick_kernel_row(1), 8, 6);
        send_rows(8, 3, PX_RANDOM);
        drain_results();
        write_reg(rcv_pkg::REG_WIDTH, 5);
        cfg_wr_en <= 1'b0;
        send_rows(5, 3, PX_RANDOM);

        // height beyond the maximum saturates; close the frame by shortening it
        configure(pick_kernel_row(1), pick_kernel_row(1), pick_kernel_row(1),
                  3, 24'h000FFF);
        send_rows(3, 4, PX_RANDOM);
        drain_results();
        write_reg(rcv_pkg::REG_HEIGHT, 3);
        cfg_wr_en <= 1'b0;
        send_rows(3, 1, PX_RANDOM);

        done_items = 0;
        phase = 0;
        while (done_items < RANDOM_ITEMS) begin
            quiet = (done_items + QUIET_TAIL >= RANDOM_ITEMS);
            style = $urandom_range(0, 2);
            w_val = {12'($urandom), ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 2))
                                                             : 12'($urandom_range(3, 12))};
            h_val = {12'($urandom), ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 2))
                                                             : 12'($urandom_range(3, 8))};
            if (phase == 1) begin
                w_val = 32;
                h_val = 6;
            end
            configure(pick_kernel_row(style), pick_kernel_row(style),
                      pick_kernel_row(style), w_val, h_val);
            tx_gaps = !quiet && $urandom_range(0, 3) != 0;
            rx_idle_on <= tx_gaps;
            // hold the result side while pixels keep coming, so the input stalls
            if (phase == 1 || (!quiet && $urandom_range(0, 9) == 0))
                hold_request <= 1'b1;
            w = sb.clip_size(w_val[rcv_pkg::SIZE_W-1:0], MAX_W);
            h = sb.clip_size(h_val[rcv_pkg::SIZE_W-1:0], MAX_H);
            nframes = $urandom_range(1, 3);
            kind = ($urandom_range(0, 4) == 0) ? PX_BINARY : PX_RANDOM;
            for (f = 0; f < nframes; f++)
                send_rows(w, h, kind);
            done_items += w * h * nframes;
            phase++;
        end

        drain_results();
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
